// ===== design/wrm_pkg.sv =====
`default_nettype none

package wrm_pkg;

	// Command codes on the request channel
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TEXT   = 2'd2;
	localparam logic [1:0] CMD_EMPTY  = 2'd3;

	// Pattern bytes with a special meaning
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE  = 8'h2E;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] symbol;
		logic       last;
	} req_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_t;

	// Classified operation, one-hot
	typedef enum logic [4:0] {
		OP_CLEAR     = 5'b00001,
		OP_APPEND    = 5'b00010,
		OP_TEXT      = 5'b00100,
		OP_TEXT_LAST = 5'b01000,
		OP_EMPTY     = 5'b10000
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] symbol;
	} job_t;

endpackage

`default_nettype wire

// ===== design/wildcard_regex_matcher_top.sv =====
// Whole-string matcher for patterns where '.' matches any byte and '*' repeats the
// element before it (a leading '*' matches nothing). Send command 0 to clear the
// pattern, 1 to append a pattern byte, 2 for a text byte (last marks the end of the
// string) and 3 to ask about the empty string; commands 2 with last and 3 return one
// beat carrying matched and pattern_overflow. Pattern bytes beyond MAX_PATTERN are
// dropped and reported through pattern_overflow until the next clear. The front queues
// up to two beats, and the back updates the whole match row for a text byte
// combinationally through a log-depth prefix over star cells, so one beat per cycle
// is sustained in each direction while results are taken. A request passes through
// the queue and then the result register before its result is valid. While a result
// waits to be taken the back stalls, and the queue takes up to two more beats before
// the request side stalls too.
`default_nettype none

module wildcard_regex_matcher_top #(
	parameter int MAX_PATTERN = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire wrm_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output wrm_pkg::rsp_t      rsp
);

	import wrm_pkg::*;

	logic job_valid;
	logic job_ready;
	job_t job;

	// Accept and classify
	wrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// Match and report
	wrm_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== design/wrm_fifo.sv =====
`default_nettype none

module wrm_fifo #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + CW'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/wrm_front.sv =====
`default_nettype none

module wrm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire wrm_pkg::req_t req,
	output logic               job_valid,
	input  wire logic          job_ready,
	output wrm_pkg::job_t      job
);

	import wrm_pkg::*;

	job_t             job_in;
	logic [$bits(job_t)-1:0] job_out;

	// Classify the request into a back-end operation
	always_comb begin
		job_in.symbol = req.symbol;
		case (req.command)
			CMD_CLEAR:  job_in.op = OP_CLEAR;
			CMD_APPEND: job_in.op = OP_APPEND;
			CMD_TEXT:   job_in.op = req.last ? OP_TEXT_LAST : OP_TEXT;
			CMD_EMPTY:  job_in.op = OP_EMPTY;
			default:    job_in.op = OP_EMPTY;
		endcase
	end

	// Queue classified beats towards the back end
	wrm_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req_valid),
		.push_ready (req_ready),
		.push_data  (job_in),
		.pop_valid  (job_valid),
		.pop_ready  (job_ready),
		.pop_data   (job_out)
	);

	assign job = job_t'(job_out);

endmodule

`default_nettype wire

// ===== design/wrm_back.sv =====
`default_nettype none

module wrm_back #(
	parameter int MAX_PATTERN = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire wrm_pkg::job_t job,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output wrm_pkg::rsp_t      rsp
);

	import wrm_pkg::*;

	localparam int M      = MAX_PATTERN;
	localparam int LW     = $clog2(M + 1);
	localparam int PW     = $clog2(M);
	localparam int LEVELS = $clog2(M);
	localparam logic [M:0] ROW_INIT = (M + 1)'(1);

	logic [7:0]    pat_q [M];
	logic [LW-1:0] len_q;
	logic [M:0]    etr_q;
	logic [M:0]    row_q;
	logic          in_text_q;
	logic          ovf_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          fire;
	logic [M:0]    prev_row;
	logic [M:0]    g_lv [LEVELS+1];
	logic [M:0]    p_lv [LEVELS+1];
	logic [M:0]    next_row;
	logic          pat_full;
	logic [LW-1:0] new_len;
	logic          etr_bit;

	assign job_ready = !rsp_valid_q || rsp_ready;
	assign fire      = job_valid && job_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign prev_row = in_text_q ? row_q : etr_q;

	always_comb begin
		// Per-cell terms: g is the cell's own hit, p lets a star cell inherit from two cells below
		g_lv[0] = '0;
		p_lv[0] = '0;
		for (int j = 1; j <= M; j++) begin
			if (LW'(j) <= len_q) begin
				if (pat_q[j-1] == STAR_BYTE) begin
					if (j >= 2) begin
						p_lv[0][j] = 1'b1;
						g_lv[0][j] = ((pat_q[j-2] == DOT_BYTE) || (pat_q[j-2] == job.symbol))
							&& prev_row[j];
					end
				end else begin
					g_lv[0][j] = ((pat_q[j-1] == DOT_BYTE) || (pat_q[j-1] == job.symbol))
						&& prev_row[j-1];
				end
			end
		end
		// Resolve chains of star cells with a parallel prefix over stride-two links
		for (int k = 0; k < LEVELS; k++) begin
			g_lv[k+1] = g_lv[k];
			p_lv[k+1] = '0;
			for (int j = (2 << k); j <= M; j++) begin
				g_lv[k+1][j] = g_lv[k][j] | (p_lv[k][j] & g_lv[k][j-(2<<k)]);
				p_lv[k+1][j] = p_lv[k][j] & p_lv[k][j-(2<<k)];
			end
		end
	end

	assign next_row = g_lv[LEVELS];

	// Empty-text bit for a newly appended cell
	assign pat_full = (len_q >= LW'(M));
	assign new_len  = len_q + LW'(1);
	assign etr_bit  = (job.symbol == STAR_BYTE) && (len_q != '0) && etr_q[len_q - LW'(1)];

	// Write the pattern store
	always_ff @(posedge clk) begin
		if (fire && (job.op == OP_APPEND) && !pat_full) begin
			pat_q[len_q[PW-1:0]] <= job.symbol;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.pattern_overflow <= ovf_q;
			rsp_q.matched <= (job.op == OP_TEXT_LAST) ? next_row[len_q] : etr_q[len_q];
		end
	end

	// Execute one operation per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			etr_q       <= ROW_INIT;
			row_q       <= ROW_INIT;
			in_text_q   <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Raise a result on a reporting beat, drop it once taken
			if (fire) begin
				rsp_valid_q <= (job.op == OP_TEXT_LAST) || (job.op == OP_EMPTY);
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (fire) begin
				case (job.op)
					OP_CLEAR: begin
						len_q     <= '0;
						etr_q     <= ROW_INIT;
						row_q     <= ROW_INIT;
						in_text_q <= 1'b0;
						ovf_q     <= 1'b0;
					end
					OP_APPEND: begin
						in_text_q <= 1'b0;
						if (pat_full) begin
							ovf_q <= 1'b1;
						end else begin
							len_q          <= new_len;
							etr_q[new_len] <= etr_bit;
						end
					end
					OP_TEXT: begin
						row_q     <= next_row;
						in_text_q <= 1'b1;
					end
					OP_TEXT_LAST: begin
						row_q     <= next_row;
						in_text_q <= 1'b0;
					end
					OP_EMPTY: begin
						in_text_q <= 1'b0;
					end
					default: begin
						in_text_q <= 1'b0;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
